[design/stfp_pkg.sv]
package stfp_pkg;

   // field widths
   localparam int unsigned OPCODE_W  = 1;
   localparam int unsigned INDEX_W   = 10;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned LEN_W     = 11;
   localparam int unsigned POS_W     = 27;
   localparam int unsigned FRAC_W    = 16;

   // table depth default and list length after reset
   localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;
   localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = LEN_W'(1024);

   // 1.0 in the fraction format, one bit wider than the fraction
   localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

   // word opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

endpackage

[design/stfp_ram.sv]
module stfp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/stfp_div.sv]
module stfp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [stfp_pkg::VALUE_W-1:0] dividend,
   input  logic [stfp_pkg::VALUE_W-1:0] divisor,
   output logic                         done,
   output logic [stfp_pkg::FRAC_W-1:0]  quotient
);

   // restoring division of (dividend << FRAC_W) by divisor, dividend < divisor
   localparam int unsigned VW  = stfp_pkg::VALUE_W;
   localparam int unsigned FW  = stfp_pkg::FRAC_W;
   localparam int unsigned CW  = $clog2(FW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] divisor_ff, divisor_in;
   logic [FW-1:0] quo_ff, quo_in;

   logic [VW:0]   shifted;
   logic [VW+1:0] diff;
   logic          fits;

   always_comb begin
      shifted    = {rem_ff, 1'b0};
      diff       = {1'b0, shifted} - {2'b00, divisor_ff};
      fits       = ~diff[VW+1];
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = dividend;
         divisor_in = divisor;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in   = {quo_ff[FW-2:0], fits};
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(FW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/sorted_table_fractional_position.sv]
// Sorted-table fractional position finder. A load word (opcode 0) writes one signed
// Q16.16 entry of an ascending table; an entry_index at or beyond TABLE_DEPTH is
// dropped. A query word (opcode 1) binary-searches the first list_length entries and
// returns a 1-based position with 16 fraction bits, interpolated linearly toward the
// neighbor that brackets the value; values at or below the first entry give 1,
// values above the last give list_length, and a zero spread between neighbors gives
// the probe index itself. A query reads the first entry from the table RAM, then
// makes one table RAM read per binary-search probe (about log2(list_length)+1
// probes), closes the search when no probe hits exactly, fetches the neighbor, forms
// the fraction in 16 steps of the serial restoring divider plus its done flag, and
// hands off the result. The input is not ready while a query is in flight. The
// result sits in an output register, so the next word is taken while it waits. Only
// entries that were loaded may be touched by a query.
module sorted_table_fractional_position #(
   parameter int unsigned TABLE_DEPTH = stfp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stfp_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [stfp_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [stfp_pkg::VALUE_W-1:0] req_sample_value,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [stfp_pkg::POS_W-1:0]          rsp_position,
   // list length register
   input  logic                                csr_write_enable,
   input  logic [stfp_pkg::LEN_W-1:0]          csr_write_data
);

   localparam int unsigned VW     = stfp_pkg::VALUE_W;
   localparam int unsigned FW     = stfp_pkg::FRAC_W;
   localparam int unsigned PW     = stfp_pkg::POS_W;
   localparam int unsigned LW     = stfp_pkg::LEN_W;
   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   // search bounds must hold the list length plus one
   localparam int unsigned CNT_W  = ($clog2(TABLE_DEPTH + 2) > LW + 1) ?
                                    $clog2(TABLE_DEPTH + 2) : LW + 1;

   // query sequencer, one-hot
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FIRST  = 8'b0000_0010,  // first entry arrives from ram
      ST_PROBE  = 8'b0000_0100,  // pick midpoint, issue read
      ST_CHECK  = 8'b0000_1000,  // compare probe entry
      ST_DECIDE = 8'b0001_0000,  // choose side, fetch neighbor
      ST_OTHER  = 8'b0010_0000,  // neighbor arrives, form ratio
      ST_DIVIDE = 8'b0100_0000,  // serial fraction
      ST_OUTPUT = 8'b1000_0000   // hand result to output register
   } state_type;

   state_type            state_ff, state_in;
   logic [LW-1:0]        list_length_ff, list_length_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]        rsp_position_ff, rsp_position_in;

   logic signed [VW-1:0] e_ff, e_in;       // query value
   logic signed [VW-1:0] lm_ff, lm_in;     // entry at probe index
   logic [CNT_W-1:0]     n_ff, n_in;       // effective list length
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     m_ff, m_in;       // probe index, 1-based
   logic                 up_ff, up_in;     // interpolate toward next entry
   logic [PW-1:0]        pos_ff, pos_in;

   // table ram
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [VW-1:0]        ram_rd_data;
   logic signed [VW-1:0] rd_value;

   // divider
   logic                 div_start;
   logic [VW-1:0]        div_dividend;
   logic [VW-1:0]        div_divisor;
   logic                 div_done;
   logic [FW-1:0]        div_quotient;

   logic                 req_accept;
   logic                 is_query;
   logic [CNT_W-1:0]     len_ext;
   logic [CNT_W-1:0]     n_eff;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid;
   logic [PW-1:0]        base;
   logic [FW:0]          frac_sel;
   logic [PW-1:0]        pos_calc;
   logic signed [VW:0]   num;              // e - lm
   logic signed [VW:0]   den;              // neighbor - lm
   logic [VW:0]          num_abs;
   logic [VW:0]          den_abs;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign is_query   = (req_opcode == stfp_pkg::OP_QUERY);

   // loads go straight into the table, out-of-range indexes dropped
   assign ram_wr_en   = req_accept && (req_opcode == stfp_pkg::OP_LOAD) &&
                        (32'(req_entry_index) < TABLE_DEPTH);
   assign ram_wr_addr = ADDR_W'(req_entry_index);
   assign rd_value    = $signed(ram_rd_data);

   // clamp list length to 1..TABLE_DEPTH
   assign len_ext = CNT_W'(list_length_ff);
   always_comb begin
      if (list_length_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (len_ext > CNT_W'(TABLE_DEPTH)) begin
         n_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         n_eff = len_ext;
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];

   // probe index as integer part, fraction added or taken off
   assign base     = PW'({m_ff, {FW{1'b0}}});
   assign pos_calc = up_ff ? (base + PW'(frac_sel)) : (base - PW'(frac_sel));

   // interpolation operands against the neighbor just read
   assign num     = {e_ff[VW-1], e_ff} - {lm_ff[VW-1], lm_ff};
   assign den     = {rd_value[VW-1], rd_value} - {lm_ff[VW-1], lm_ff};
   assign num_abs = num[VW] ? -num : num;
   assign den_abs = den[VW] ? -den : den;

   assign div_dividend = num_abs[VW-1:0];
   assign div_divisor  = den_abs[VW-1:0];

   always_comb begin
      state_in        = state_ff;
      list_length_in  = csr_write_enable ? csr_write_data : list_length_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_position_in = rsp_position_ff;
      e_in            = e_ff;
      lm_in           = lm_ff;
      n_in            = n_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      m_in            = m_ff;
      up_in           = up_ff;
      pos_in          = pos_ff;
      ram_rd_addr     = '0;
      div_start       = 1'b0;
      frac_sel        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               e_in        = req_sample_value;
               n_in        = n_eff;
               m_in        = CNT_W'(1);
               ram_rd_addr = '0;
               state_in    = ST_FIRST;
            end
         end
         ST_FIRST: begin
            // first entry not below the value: stop at position one
            lm_in = rd_value;
            if (rd_value < e_ff) begin
               lo_in    = CNT_W'(1);
               hi_in    = n_ff;
               state_in = ST_PROBE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_PROBE: begin
            if (lo_ff <= hi_ff) begin
               m_in        = mid;
               ram_rd_addr = ADDR_W'(mid - CNT_W'(1));
               state_in    = ST_CHECK;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_CHECK: begin
            lm_in = rd_value;
            if (rd_value == e_ff) begin
               state_in = ST_DECIDE;
            end else if (rd_value < e_ff) begin
               lo_in    = m_ff + CNT_W'(1);
               state_in = ST_PROBE;
            end else begin
               hi_in    = m_ff - CNT_W'(1);
               state_in = ST_PROBE;
            end
         end
         ST_DECIDE: begin
            up_in = (lm_ff <= e_ff);
            if (lm_ff <= e_ff) begin
               // last entry in use: nothing above to interpolate to
               if (m_ff == n_ff) begin
                  pos_in   = base;
                  state_in = ST_OUTPUT;
               end else begin
                  ram_rd_addr = ADDR_W'(m_ff);
                  state_in    = ST_OTHER;
               end
            end else begin
               if (m_ff <= CNT_W'(1)) begin
                  pos_in   = base;
                  state_in = ST_OUTPUT;
               end else begin
                  ram_rd_addr = ADDR_W'(m_ff - CNT_W'(2));
                  state_in    = ST_OTHER;
               end
            end
         end
         ST_OTHER: begin
            // zero spread, zero offset or wrong sign give no fraction;
            // a ratio of one or more saturates
            priority if (den == '0 || num == '0 || num[VW] != den[VW]) begin
               pos_in   = pos_calc;
               state_in = ST_OUTPUT;
            end else if (num_abs >= den_abs) begin
               frac_sel = stfp_pkg::FRAC_ONE;
               pos_in   = pos_calc;
               state_in = ST_OUTPUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            frac_sel = {1'b0, div_quotient};
            if (div_done) begin
               pos_in   = pos_calc;
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = pos_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         list_length_ff <= stfp_pkg::LIST_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         list_length_ff <= list_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff <= rsp_position_in;
      e_ff            <= e_in;
      lm_ff           <= lm_in;
      n_ff            <= n_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      m_ff            <= m_in;
      up_ff           <= up_in;
      pos_ff          <= pos_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

   stfp_ram #(
      .WIDTH (VW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   stfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule
